### hw/rtl/jcc_pkg.sv
// Package for the Johab code converter: transaction types, operation codes, jamo tables.
package jcc_pkg;

    // Operation codes
    localparam logic [1:0] OP_JOHAB_TO_IDX = 2'd0;
    localparam logic [1:0] OP_IDX_TO_JOHAB = 2'd1;
    localparam logic [1:0] OP_JOHAB_TO_KS  = 2'd2;
    localparam logic [1:0] OP_KS_TO_JOHAB  = 2'd3;

    // Last valid syllable number
    localparam logic [15:0] SYL_LAST = 16'd11171;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] code_in;
    } req_t;

    typedef struct packed {
        logic [15:0] code_out;
        logic        bad_code;
    } rsp_t;

    // Jamo field -> 1-based index, zero means no such jamo
    localparam logic [4:0] JAMO_TO_INIT [32] = '{
        5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
        5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };
    localparam logic [4:0] JAMO_TO_MED [32] = '{
        5'd0,  5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,
        5'd0,  5'd0,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd0,  5'd0,  5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
        5'd0,  5'd0,  5'd18, 5'd19, 5'd20, 5'd21, 5'd0,  5'd0
    };
    localparam logic [4:0] JAMO_TO_FIN [32] = '{
        5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
        5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
        5'd16, 5'd17, 5'd0,  5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd0,  5'd0
    };

    // 0-based index -> jamo field
    localparam logic [4:0] INIT_TO_JAMO [32] = '{
        5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
        5'd18, 5'd19, 5'd20, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };
    localparam logic [4:0] MED_TO_JAMO [32] = '{
        5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd15, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
        5'd23, 5'd26, 5'd27, 5'd28, 5'd29, 5'd0,  5'd0,  5'd0,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };
    localparam logic [4:0] FIN_TO_JAMO [32] = '{
        5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
        5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
        5'd17, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
        5'd26, 5'd27, 5'd28, 5'd29, 5'd0,  5'd0,  5'd0,  5'd0
    };

endpackage

### hw/rtl/johab_code_converter.sv
// Johab code converter top level: three-stage pipeline for all four conversions.
//
// Takes one conversion transaction per cycle on req while rsp is not stalled and
// returns one result per transaction on rsp, in order. Op 0 turns a Johab Hangul
// code into a syllable number (bad_code when a jamo field is unassigned; bit 15
// is ignored), op 1 turns a syllable number back into Johab with bit 15 set
// (bad_code above 11171), op 2 maps a Johab symbol or Hanja code to a KS X 1001
// row/column pair and op 3 maps a KS X 1001 code back, with 8-bit wrapping byte
// arithmetic and no range check. The stage split is set by the chain of the
// syllable math: stage 1 does the jamo table lookups, the division by 28
// (reciprocal multiply) and the KS X 1001 byte math, stage 2 the division by 21
// and the initial/medial combine, stage 3 the final scale by 28 and the reverse
// table lookups into the output register. Each stage holds its own valid bit and
// moves on whenever the stage after it is empty or draining, so bubbles collapse
// and a full pipeline keeps one result per cycle while rsp_ready stays high.
module johab_code_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  jcc_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output jcc_pkg::rsp_t  rsp
);

    typedef struct packed {
        logic [1:0]  op;
        logic        bad;
        logic [4:0]  ia;        // 1-based initial index
        logic [4:0]  ib;        // 1-based medial index
        logic [4:0]  ic;        // 1-based final index
        logic [8:0]  q28;       // syllable / 28
        logic [4:0]  n_lo;      // syllable low bits for the remainder
        logic [15:0] ks;        // finished op 2 / op 3 result
    } s1_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        bad;
        logic [8:0]  t;         // (I-1)*21 + (M-1)
        logic [4:0]  ic;
        logic [8:0]  q28;
        logic [4:0]  q21;       // initial index, 0-based
        logic [4:0]  r28;       // final index, 0-based
        logic [15:0] ks;
    } s2_t;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    jcc_pkg::rsp_t s3_reg, s3_next;

    logic en1, en2, en3;

    // Per-stage advance: a stage loads when it is empty or its content moves on
    assign en3       = !s3_valid_reg || rsp_ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req_ready = en1;

    // ---------------- stage 1 ----------------
    logic [7:0]  hi, lo, hi_a, lo_a;
    logic [7:0]  khi, klo, kbase, kh, klo_a, khi_a;
    logic [23:0] prod28;

    always_comb
    begin
        s1_next    = '0;
        s1_next.op = req.op;

        s1_next.ia = jcc_pkg::JAMO_TO_INIT[req.code_in[14:10]];
        s1_next.ib = jcc_pkg::JAMO_TO_MED[req.code_in[9:5]];
        s1_next.ic = jcc_pkg::JAMO_TO_FIN[req.code_in[4:0]];

        // n/28 = (n>>2)/7, reciprocal exact for every valid syllable number
        prod28      = 24'(req.code_in[13:2]) * 24'd2341;
        s1_next.q28 = prod28[22:14];
        s1_next.n_lo = req.code_in[4:0];

        // Johab symbol/Hanja to KS X 1001
        hi = req.code_in[15:8];
        lo = req.code_in[7:0];
        if (hi < 8'he0)
            hi_a = 8'((hi - 8'hd8) << 1) + 8'h1f;
        else
            hi_a = 8'((hi - 8'he0) << 1) + 8'h4a;
        if (lo < 8'ha1)
        begin
            lo_a = lo - ((lo < 8'h91) ? 8'h10 : 8'h22);
        end
        else
        begin
            hi_a = hi_a + 8'd1;
            lo_a = lo - 8'h80;
        end

        // KS X 1001 back to Johab, bytes masked to 7 bits
        khi   = {1'b0, req.code_in[14:8]};
        klo   = {1'b0, req.code_in[6:0]};
        kbase = (khi < 8'h4a) ? 8'hd8 : 8'he0;
        kh    = khi - ((khi < 8'h4a) ? 8'h1f : 8'h4a);
        klo_a = klo + (kh[0] ? 8'h80 : ((klo < 8'h6f) ? 8'h10 : 8'h22));
        khi_a = (kh >> 1) + kbase;

        case (req.op)
            jcc_pkg::OP_JOHAB_TO_IDX:
            begin
                s1_next.bad = (s1_next.ia == 5'd0) || (s1_next.ib == 5'd0) ||
                              (s1_next.ic == 5'd0);
                s1_next.ks  = '0;
            end
            jcc_pkg::OP_IDX_TO_JOHAB:
            begin
                s1_next.bad = req.code_in > jcc_pkg::SYL_LAST;
                s1_next.ks  = '0;
            end
            jcc_pkg::OP_JOHAB_TO_KS:
            begin
                s1_next.bad = 1'b0;
                s1_next.ks  = {hi_a, lo_a};
            end
            default:
            begin
                s1_next.bad = 1'b0;
                s1_next.ks  = {khi_a, klo_a};
            end
        endcase
    end

    // ---------------- stage 2 ----------------
    logic [17:0] prod21;

    always_comb
    begin
        s2_next     = '0;
        s2_next.op  = s1_reg.op;
        s2_next.bad = s1_reg.bad;
        s2_next.ks  = s1_reg.ks;
        s2_next.ic  = s1_reg.ic;
        s2_next.q28 = s1_reg.q28;
        s2_next.t   = (9'(s1_reg.ia) - 9'd1) * 9'd21 + (9'(s1_reg.ib) - 9'd1);
        s2_next.r28 = 5'(s1_reg.n_lo - 5'(s1_reg.q28 * 9'd28));
        // q/21 by reciprocal, exact for q up to 430
        prod21      = 18'(s1_reg.q28) * 18'd391;
        s2_next.q21 = prod21[17:13];
    end

    // ---------------- stage 3 ----------------
    logic [13:0] syl;
    logic [4:0]  r21;

    always_comb
    begin
        s3_next = '0;
        syl     = 14'(s2_reg.t) * 14'd28 + 14'(s2_reg.ic) - 14'd1;
        r21     = 5'(s2_reg.q28 - 9'(s2_reg.q21) * 9'd21);
        s3_next.bad_code = s2_reg.bad;
        if (s2_reg.bad)
        begin
            s3_next.code_out = '0;
        end
        else
        begin
            case (s2_reg.op)
                jcc_pkg::OP_JOHAB_TO_IDX:
                    s3_next.code_out = {2'b00, syl};
                jcc_pkg::OP_IDX_TO_JOHAB:
                    s3_next.code_out = {1'b1,
                                        jcc_pkg::INIT_TO_JAMO[s2_reg.q21],
                                        jcc_pkg::MED_TO_JAMO[r21],
                                        jcc_pkg::FIN_TO_JAMO[s2_reg.r28]};
                default:
                    s3_next.code_out = s2_reg.ks;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= req_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
    end

    assign rsp_valid = s3_valid_reg;
    assign rsp       = s3_reg;

    // ---------------- assertions ----------------
    // An accepted transaction lands in stage 1
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> s1_valid_reg)
        else $error("accepted transaction did not reach stage 1");

    // Reciprocal divide by 21 gives a legal initial index
    a_q21_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.op == jcc_pkg::OP_IDX_TO_JOHAB) && !s2_reg.bad)
            |-> (s2_reg.q21 <= 5'd18))
        else $error("initial index out of range");

    // Remainder by 28 is a legal final index
    a_r28_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && (s2_reg.op == jcc_pkg::OP_IDX_TO_JOHAB) && !s2_reg.bad)
            |-> (s2_reg.r28 <= 5'd27))
        else $error("final index out of range");

    // A flagged result carries a zero code
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.bad_code) |-> (rsp.code_out == 16'd0))
        else $error("flagged result with nonzero code");

endmodule
